[hdl/fir64_pkg.sv]
// Shared types, constants and coefficient table for the 64-tap low-pass FIR.
// No dependencies; used by every module of the filter except fir64_ram.
`default_nettype none

package fir64_pkg;

    localparam int SAMPLE_WIDTH_DEF = 20;
    localparam int IN_W             = 20;
    localparam int OUT_W            = 21;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 24;
    localparam int TAP_COUNT        = 64;
    localparam int HIST_DEPTH       = TAP_COUNT - 1;
    localparam int TAP_IDX_W        = $clog2(TAP_COUNT);
    localparam int HIST_ADDR_W      = $clog2(HIST_DEPTH);
    localparam int CNT_W            = $clog2(HIST_DEPTH + 1);
    localparam int COEF_W           = 13;
    localparam int PROD_SHIFT       = 8;

    // index 0 weights the oldest sample, the last index the newest
    localparam logic signed [COEF_W-1:0] COEF_TABLE [TAP_COUNT] = '{
        -13'sd30,   -13'sd56,   -13'sd85,   -13'sd115,
        -13'sd145,  -13'sd176,  -13'sd206,  -13'sd233,
        -13'sd257,  -13'sd278,  -13'sd292,  -13'sd301,
        -13'sd300,  -13'sd293,  -13'sd275,  -13'sd247,
        -13'sd207,  -13'sd156,  -13'sd93,   -13'sd18,
        13'sd70,    13'sd170,   13'sd282,   13'sd406,
        13'sd540,   13'sd683,   13'sd834,   13'sd990,
        13'sd1152,  13'sd1315,  13'sd1479,  13'sd1641,
        13'sd1799,  13'sd1950,  13'sd2092,  13'sd2223,
        13'sd2342,  13'sd2444,  13'sd2531,  13'sd2599,
        13'sd2648,  13'sd2676,  13'sd2685,  13'sd2671,
        13'sd2638,  13'sd2585,  13'sd2512,  13'sd2422,
        13'sd2316,  13'sd2196,  13'sd2064,  13'sd1922,
        13'sd1773,  13'sd1619,  13'sd1464,  13'sd1309,
        13'sd1157,  13'sd1011,  13'sd871,   13'sd741,
        13'sd623,   13'sd518,   13'sd438,   13'sd462
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } fir64_state_t;

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic                 zero;
        logic [TAP_IDX_W-1:0] tap;
    } fir64_issue_t;

    typedef struct packed {
        logic         take;
        fir64_issue_t issue;
    } fir64_mac_ctl_t;

endpackage

`default_nettype wire

[hdl/fir64_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fir64_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/fir64_mac.sv]
// Shared multiply-accumulate unit: one tap per cycle, three-stage pipeline.
// Depends on fir64_pkg; fed by fir64_ctrl and the history RAM.
`default_nettype none

module fir64_mac
    import fir64_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire fir64_mac_ctl_t          ctl,
    input  wire logic [SAMPLE_WIDTH-1:0] hist_data,
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    output logic                         res_valid,
    output logic [OUT_W-1:0]             result
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int SH_W   = PROD_W - PROD_SHIFT;
    localparam int SUM_W  = SH_W + TAP_IDX_W;
    localparam int ACC_W  = (SUM_W > OUT_W + PROD_SHIFT) ? SUM_W : OUT_W + PROD_SHIFT;

    fir64_issue_t              a_iss_reg;
    logic signed [SAMPLE_WIDTH-1:0] operand;
    logic signed [COEF_W-1:0]  coef;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  b_prod_reg;
    logic                      b_valid_reg;
    logic                      b_first_reg;
    logic                      b_last_reg;
    logic signed [ACC_W-1:0]   acc_add;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      res_valid_reg;
    logic                      res_valid_next;

    always_comb
    begin
        if (a_iss_reg.last)
        begin
            operand = $signed(sample);
        end
        else if (a_iss_reg.zero)
        begin
            operand = '0;
        end
        else
        begin
            operand = $signed(hist_data);
        end
        coef      = COEF_TABLE[a_iss_reg.tap];
        prod_next = operand * coef;
    end

    // floor shift of each product, sign-extended to accumulator width
    assign acc_add = ACC_W'($signed(b_prod_reg[PROD_W-1:PROD_SHIFT]));

    always_comb
    begin
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg;
        if (b_valid_reg)
        begin
            acc_next = (b_first_reg ? ACC_W'(0) : acc_reg) + acc_add;
            if (b_last_reg)
            begin
                res_valid_next = 1'b1;
            end
        end
        if (ctl.take)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_iss_reg     <= '0;
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            a_iss_reg     <= ctl.issue;
            b_valid_reg   <= a_iss_reg.valid;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_prod_reg  <= prod_next;
        b_first_reg <= a_iss_reg.first;
        b_last_reg  <= a_iss_reg.last;
        acc_reg     <= acc_next;
    end

    assign res_valid = res_valid_reg;
    assign result    = acc_reg[OUT_W+PROD_SHIFT-1:PROD_SHIFT];

endmodule

`default_nettype wire

[hdl/fir64_ctrl.sv]
// Sequencer: steps the MAC through all taps, owns history pointers and fill count.
// Depends on fir64_pkg; drives fir64_mac and the history RAM.
`default_nettype none

module fir64_ctrl
    import fir64_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             res_valid,
    input  wire logic             out_free,
    output logic                  load,
    output fir64_mac_ctl_t        ctl,
    output logic [HIST_ADDR_W-1:0] raddr,
    output logic                  we,
    output logic [HIST_ADDR_W-1:0] waddr
);

    localparam int SUM_W = ((TAP_IDX_W > CNT_W) ? TAP_IDX_W : CNT_W) + 1;

    fir64_state_t           state_reg, state_next;
    logic [TAP_IDX_W-1:0]   idx_reg, idx_next;
    logic [HIST_ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [HIST_ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]       age_sum;
    logic                   is_last;

    // entry of oldest-first index i holds a real sample once i + count >= depth
    assign age_sum = SUM_W'(idx_reg) + SUM_W'(count_reg);
    assign is_last = (idx_reg == TAP_IDX_W'(TAP_COUNT - 1));

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        rd_addr_next = rd_addr_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        s_tready     = 1'b0;
        load         = 1'b0;
        we           = 1'b0;
        ctl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    idx_next     = '0;
                    rd_addr_next = head_reg;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctl.issue.valid = 1'b1;
                ctl.issue.first = (idx_reg == '0);
                ctl.issue.last  = is_last;
                ctl.issue.zero  = !is_last && (age_sum < SUM_W'(HIST_DEPTH));
                ctl.issue.tap   = idx_reg;
                rd_addr_next    = (rd_addr_reg == HIST_ADDR_W'(HIST_DEPTH - 1))
                                  ? '0 : rd_addr_reg + 1'b1;
                idx_next        = idx_reg + 1'b1;
                if (is_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (res_valid && out_free)
                begin
                    load      = 1'b1;
                    ctl.take  = 1'b1;
                    we        = 1'b1;
                    head_next = (head_reg == HIST_ADDR_W'(HIST_DEPTH - 1))
                                ? '0 : head_reg + 1'b1;
                    if (count_reg != CNT_W'(HIST_DEPTH))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            rd_addr_reg <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_addr_reg <= rd_addr_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
        end
    end

    assign raddr = rd_addr_reg;
    assign waddr = head_reg;

endmodule

`default_nettype wire

[hdl/fir_lowpass_64_tap_top.sv]
// Top level of the 64-tap low-pass FIR: stream ports, sample and output registers.
// Depends on fir64_pkg, fir64_ram, fir64_mac and fir64_ctrl.
//
// One sample in, one filtered word out. A single multiplier walks the 63-entry
// history RAM (one read port, one tap per cycle) and then the new sample. m_tvalid
// rises once every tap has passed the MAC pipeline (issue, product and accumulator
// registers) and the result is loaded into the output register. s_tready is low
// while a word is in work and rises again once the result is in the output
// register, so a new word is taken only after the last one has left the MAC. If
// the output register still holds an unread word, the result waits in the MAC and
// the input stays blocked until the output register frees up. History reads as
// zero after reset through a fill count; no clearing pass is needed.
`default_nettype none

module fir_lowpass_64_tap_top
    import fir64_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [19:0] sample
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata    // [20:0] filtered
);

    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [SAMPLE_WIDTH-1:0] hist_data;
    logic [HIST_ADDR_W-1:0]  raddr;
    logic [HIST_ADDR_W-1:0]  waddr;
    logic                    we;
    logic                    load;
    logic                    res_valid;
    logic                    out_free;
    logic [OUT_W-1:0]        result;
    fir64_mac_ctl_t          ctl;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        out_data_reg;

    assign out_free = !out_valid_reg || m_tready;

    fir64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .res_valid (res_valid),
        .out_free  (out_free),
        .load      (load),
        .ctl       (ctl),
        .raddr     (raddr),
        .we        (we),
        .waddr     (waddr)
    );

    fir64_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (sample_reg),
        .raddr (raddr),
        .rdata (hist_data)
    );

    fir64_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .hist_data (hist_data),
        .sample    (sample_reg),
        .res_valid (res_valid),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

[hdl/fir64_checker.sv]
// Port-level checks for the FIR top level, bound onto fir_lowpass_64_tap_top.
// Depends on fir64_pkg.
`default_nettype none

module fir64_checker
    import fir64_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after accept");

    // ready only drops through an accepted word
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("ready dropped without an accepted word");

    // a new result shows up only at the end of a busy stretch
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output word changed");

endmodule

bind fir_lowpass_64_tap_top fir64_checker u_fir64_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
